// ===== rtl/fdf_pkg.sv =====
// shared types and codes for the dual decimating fir filter
package fdf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 32;
  localparam int ACC_W    = 32;
  localparam int IDX_W    = 6;
  localparam int GROUP_SZ = 4;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_COEF    = 1'b1;
  localparam logic CH_LOWPASS  = 1'b0;
  localparam logic CH_HIGHPASS = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [WORD_W-1:0]          lowpass_word;
    logic [WORD_W-1:0]          highpass_word;
    logic                       word_last;
    logic                       coef_channel;
    logic [IDX_W-1:0]           coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
  } fdf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lowpass_out;
    logic signed [SAMPLE_W-1:0] highpass_out;
    logic                       frame_last;
  } fdf_out_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } fdf_state_t;

  // controls from the sequencer to both filter lanes
  typedef struct packed {
    logic                       shift;
    logic                       zero_fill;
    logic [1:0]                 coef_we;
    logic [IDX_W-1:0]           coef_idx;
    logic signed [SAMPLE_W-1:0] coef_val;
    logic                       en1;
    logic                       en2;
    logic                       en3;
  } fdf_ctl_t;

endpackage

// ===== rtl/fdf_lane.sv =====
// one filter lane: tap line, coefficient bank, multipliers and registered adder tree
module fdf_lane import fdf_pkg::*; #(
  parameter int TAPS = 16,
  parameter int SPW  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fdf_ctl_t          ctl,
  input  logic              lane_we,
  input  logic [WORD_W-1:0] sample_word,
  output logic [ACC_W-1:0]  sum
);

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int NG = (TAPS + GROUP_SZ - 1) / GROUP_SZ;

  logic signed [SAMPLE_W-1:0] taps_r  [TAPS];
  logic signed [SAMPLE_W-1:0] taps_nxt[TAPS];
  logic signed [SAMPLE_W-1:0] coefs_r [TAPS];
  logic [ACC_W-1:0]           prod_r  [TAPS];
  logic [ACC_W-1:0]           prod_pad[NG*GROUP_SZ];
  logic [ACC_W-1:0]           grp_r   [NG];
  logic [ACC_W-1:0]           grp_nxt [NG];
  logic [ACC_W-1:0]           sum_r;
  logic [ACC_W-1:0]           sum_nxt;
  logic                       idx_ok;

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    if (i < SPW) begin : g_head
      // first sample sits in the upper half of the word
      assign taps_nxt[i] = ctl.zero_fill ? '0 : sample_word[SAMPLE_W*(SPW-1-i) +: SAMPLE_W];
    end else begin : g_body
      assign taps_nxt[i] = taps_r[i-SPW];
    end
  end

  for (genvar p = 0; p < NG*GROUP_SZ; p++) begin : g_pad
    if (p < TAPS) begin : g_real
      assign prod_pad[p] = prod_r[p];
    end else begin : g_zero
      assign prod_pad[p] = '0;
    end
  end

  assign idx_ok = ({1'b0, ctl.coef_idx} < (IDX_W+1)'(TAPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        taps_r[i]  <= '0;
        coefs_r[i] <= '0;
      end
    end else begin
      if (ctl.shift) begin
        taps_r <= taps_nxt;
      end
      if (lane_we && idx_ok) begin
        coefs_r[ctl.coef_idx[IW-1:0]] <= ctl.coef_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_r[i] <= ACC_W'(taps_r[i] * coefs_r[i]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NG; k++) begin
      grp_nxt[k] = '0;
      for (int j = 0; j < GROUP_SZ; j++) begin
        grp_nxt[k] = grp_nxt[k] + prod_pad[k*GROUP_SZ+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NG; k++) begin
      sum_nxt = sum_nxt + grp_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== rtl/fdf_ctrl.sv =====
// sequencer: input handshake, flush generation and pipeline stage valids
module fdf_ctrl import fdf_pkg::*; #(
  parameter int TAPS = 16,
  parameter int SPW  = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  fdf_in_t  in_data,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output logic     out_last,
  output fdf_ctl_t ctl
);

  localparam int FLUSH_N = TAPS / SPW;
  localparam int CW      = (FLUSH_N > 1) ? $clog2(FLUSH_N) : 1;

  fdf_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          v0_r, v1_r, v2_r, v3_r;
  logic          l0_r, l1_r, l2_r, l3_r;
  logic          out_en, en2, en1, s0_free;
  logic          accept, samp_acc, coef_acc;
  logic          ins_flush, flush_last;

  // a stage moves when it is empty or the next one moves
  assign out_en  = !v3_r || out_ready;
  assign en2     = !v2_r || out_en;
  assign en1     = !v1_r || en2;
  assign s0_free = !v0_r || en1;

  assign flush_last = (cnt_r == CW'(FLUSH_N - 1));
  assign accept     = in_valid && in_ready;
  assign samp_acc   = accept && (in_data.req_type == REQ_SAMPLE);
  assign coef_acc   = accept && (in_data.req_type == REQ_COEF);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_RUN: begin
        if (samp_acc && in_data.word_last) begin
          state_nxt = ST_FLUSH;
          cnt_nxt   = '0;
        end
      end
      ST_FLUSH: begin
        if (s0_free) begin
          if (flush_last) begin
            state_nxt = ST_RUN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ins_flush = 1'b0;
    unique case (state_r)
      ST_RUN:   in_ready  = s0_free;
      ST_FLUSH: ins_flush = s0_free;
      default: begin
        in_ready  = 1'b0;
        ins_flush = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      l0_r    <= 1'b0;
      l1_r    <= 1'b0;
      l2_r    <= 1'b0;
      l3_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (s0_free) begin
        v0_r <= samp_acc || ins_flush;
        l0_r <= ins_flush && flush_last;
      end
      if (en1) begin
        v1_r <= v0_r;
        l1_r <= l0_r;
      end
      if (en2) begin
        v2_r <= v1_r;
        l2_r <= l1_r;
      end
      if (out_en) begin
        v3_r <= v2_r;
        l3_r <= l2_r;
      end
    end
  end

  always_comb begin
    ctl.shift      = samp_acc || ins_flush;
    ctl.zero_fill  = ins_flush;
    ctl.coef_we[0] = coef_acc && (in_data.coef_channel == CH_LOWPASS);
    ctl.coef_we[1] = coef_acc && (in_data.coef_channel == CH_HIGHPASS);
    ctl.coef_idx   = in_data.coef_index;
    ctl.coef_val   = in_data.coef_value;
    ctl.en1        = en1;
    ctl.en2        = en2;
    ctl.en3        = out_en;
  end

  assign out_valid = v3_r;
  assign out_last  = l3_r;

endmodule

// ===== rtl/dual_decimating_fir_filter.sv =====
// top level: low-pass and high-pass lanes with sequencer and result merge
//
//   channel   ports                           moves
//   input     in_valid in_ready in_data       sample word or coefficient load
//   result    out_valid out_ready out_data    both filter outputs and frame end
//
// one sample word per cycle when in_ready; result via tap, product, group, sum regs
// a word marked last holds in_ready low while TAPS/SPW zero words flush
// each pipeline stage advances whenever it is empty, so bubbles close up under stall
// rst_n clears tap lines, coefficients and all stage valids
module dual_decimating_fir_filter import fdf_pkg::*; #(
  parameter int TAPS = 16,
  parameter int SPW  = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fdf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fdf_out_t out_data
);

  fdf_ctl_t         ctl;
  logic             out_last;
  logic [ACC_W-1:0] lp_sum;
  logic [ACC_W-1:0] hp_sum;

  fdf_ctrl #(.TAPS(TAPS), .SPW(SPW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_last (out_last),
    .ctl      (ctl)
  );

  fdf_lane #(.TAPS(TAPS), .SPW(SPW)) u_lane_lp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .lane_we    (ctl.coef_we[0]),
    .sample_word(in_data.lowpass_word),
    .sum        (lp_sum)
  );

  fdf_lane #(.TAPS(TAPS), .SPW(SPW)) u_lane_hp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .lane_we    (ctl.coef_we[1]),
    .sample_word(in_data.highpass_word),
    .sum        (hp_sum)
  );

  // upper half of each wrapped accumulator
  always_comb begin
    out_data.lowpass_out  = lp_sum[ACC_W-1 -: SAMPLE_W];
    out_data.highpass_out = hp_sum[ACC_W-1 -: SAMPLE_W];
    out_data.frame_last   = out_last;
  end

endmodule
